// ===== hdl/wps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the LED pixel serializer.
// No dependencies; every other file of the block but wps_ram refers to this package.
package wps_pkg;

	localparam int NUM_LEDS_DEF = 256;
	localparam int PIXEL_W      = 24;
	localparam int IDX_W        = 9;
	localparam int COLOR_W      = 8;
	localparam int TICK_W       = 16;
	localparam int BIT_CNT_W    = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = 2'd3;

	localparam logic [7:0]        ZERO_HIGH_RST  = 8'd1;
	localparam logic [7:0]        ONE_HIGH_RST   = 8'd3;
	localparam logic [7:0]        BIT_PERIOD_RST = 8'd4;
	localparam logic [TICK_W-1:0] RESET_LOW_RST  = 16'd1200;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_REFRESH = 2'd1,
		REQ_TICK    = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_RESET = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [IDX_W-1:0]   index_or_count;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} req_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} result_t;

endpackage

// ===== hdl/wps_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the LED pixel serializer: request words in, result words out.
// Depends on wps_pkg for field widths.
interface wps_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [wps_pkg::IDX_W-1:0]   index_or_count;
	logic [wps_pkg::COLOR_W-1:0] red;
	logic [wps_pkg::COLOR_W-1:0] green;
	logic [wps_pkg::COLOR_W-1:0] blue;

	modport source (output valid, req_type, index_or_count, red, green, blue, input ready);
	modport sink   (input valid, req_type, index_or_count, red, green, blue, output ready);
endinterface

interface wps_res_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic frame_done;

	modport source (output valid, line_level, busy_res, frame_done, input ready);
	modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ===== hdl/wps_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module wps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/wps_engine.sv =====
`timescale 1ns / 1ps
// Frame engine: configuration registers, pixel store access, bit-cell timing and phases.
// Depends on wps_pkg and wps_ram.
module wps_engine #(
	parameter int NUM_LEDS = wps_pkg::NUM_LEDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [wps_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [wps_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                acc,
	input  wps_pkg::req_item_t                  item,
	output wps_pkg::result_t                    res,
	output logic                                clearing
);

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int CW = $clog2(NUM_LEDS + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LEDS - 1);

	wps_pkg::phase_t phase_q, phase_d;

	logic [CW-1:0]                     led_q, led_d;
	logic [CW-1:0]                     len_q, len_d;
	logic [CW-1:0]                     fetch_q, fetch_d;
	logic [wps_pkg::BIT_CNT_W-1:0]     bit_q, bit_d;
	logic [wps_pkg::TICK_W-1:0]        tick_q, tick_d;
	logic                              level_q, level_d;
	logic                              pending_q, pending_d;
	logic [wps_pkg::PIXEL_W-1:0]       word_q, word_d;
	logic                              clearing_q;
	logic [AW-1:0]                     clr_q;
	logic [7:0]                        zh_q, oh_q, bp_q;
	logic [wps_pkg::TICK_W-1:0]        rl_q;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [wps_pkg::PIXEL_W-1:0]       ram_wdata;
	logic [wps_pkg::PIXEL_W-1:0]       ram_rdata;

	logic [wps_pkg::PIXEL_W-1:0]       word;
	logic                              cur_bit;
	logic [7:0]                        high;
	logic [7:0]                        period;
	logic [wps_pkg::TICK_W-1:0]        rst_len;
	logic [wps_pkg::TICK_W-1:0]        tick_n;
	logic [CW-1:0]                     led_n;
	logic                              lvl;

	wps_ram #(
		.WIDTH (wps_pkg::PIXEL_W),
		.DEPTH (NUM_LEDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (1'b1),
		.raddr (AW'(fetch_d)),
		.rdata (ram_rdata)
	);

	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zh_q <= wps_pkg::ZERO_HIGH_RST;
			oh_q <= wps_pkg::ONE_HIGH_RST;
			bp_q <= wps_pkg::BIT_PERIOD_RST;
			rl_q <= wps_pkg::RESET_LOW_RST;
		end else if (wr_en) begin
			case (wr_index)
				wps_pkg::REG_ZERO_HIGH:  zh_q <= wr_data[7:0];
				wps_pkg::REG_ONE_HIGH:   oh_q <= wr_data[7:0];
				wps_pkg::REG_BIT_PERIOD: bp_q <= wr_data[7:0];
				wps_pkg::REG_RESET_LOW:  rl_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wps_pkg::PH_IDLE;
			led_q     <= '0;
			len_q     <= '0;
			fetch_q   <= '0;
			bit_q     <= '0;
			tick_q    <= '0;
			level_q   <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			led_q     <= led_d;
			len_q     <= len_d;
			fetch_q   <= fetch_d;
			bit_q     <= bit_d;
			tick_q    <= tick_d;
			level_q   <= level_d;
			pending_q <= pending_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	always_comb begin
		phase_d   = phase_q;
		led_d     = led_q;
		len_d     = len_q;
		fetch_d   = fetch_q;
		bit_d     = bit_q;
		tick_d    = tick_q;
		level_d   = level_q;
		pending_d = pending_q;
		word_d    = word_q;

		ram_we    = 1'b0;
		ram_waddr = AW'(item.index_or_count);
		ram_wdata = {item.green, item.red, item.blue};

		word    = pending_q ? ram_rdata : word_q;
		cur_bit = word[wps_pkg::LAST_BIT - bit_q];
		high    = cur_bit ? oh_q : zh_q;
		period  = (bp_q == 8'd0) ? 8'd1 : bp_q;
		rst_len = (rl_q == '0) ? wps_pkg::TICK_W'(1) : rl_q;
		tick_n  = tick_q + wps_pkg::TICK_W'(1);
		led_n   = led_q + CW'(1);
		lvl     = tick_q < {8'd0, high};

		res.line_level = level_q;
		res.busy_res   = phase_q != wps_pkg::PH_IDLE;
		res.frame_done = 1'b0;

		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end

		// load first pixel of the frame, prefetch the next one
		if (pending_q) begin
			word_d    = ram_rdata;
			pending_d = 1'b0;
			fetch_d   = fetch_q + CW'(1);
		end

		if (acc) begin
			case (item.req_type)
				wps_pkg::REQ_WRITE: begin
					if (phase_q == wps_pkg::PH_IDLE &&
					    32'(item.index_or_count) < 32'(NUM_LEDS)) begin
						ram_we = 1'b1;
					end
				end
				wps_pkg::REQ_REFRESH: begin
					if (phase_q == wps_pkg::PH_IDLE) begin
						if (32'(item.index_or_count) > 32'(NUM_LEDS)) begin
							len_d = CW'(NUM_LEDS);
						end else begin
							len_d = CW'(item.index_or_count);
						end
						led_d     = '0;
						bit_d     = '0;
						tick_d    = '0;
						fetch_d   = '0;
						pending_d = 1'b1;
						phase_d   = (len_d == '0) ? wps_pkg::PH_RESET : wps_pkg::PH_DATA;
					end
					res.busy_res = phase_d != wps_pkg::PH_IDLE;
				end
				wps_pkg::REQ_TICK: begin
					case (phase_q)
						wps_pkg::PH_DATA: begin
							level_d        = lvl;
							res.line_level = lvl;
							res.busy_res   = 1'b1;
							if (tick_n >= {8'd0, period}) begin
								tick_d = '0;
								if (bit_q == wps_pkg::LAST_BIT) begin
									bit_d   = '0;
									led_d   = led_n;
									word_d  = ram_rdata;
									fetch_d = fetch_q + CW'(1);
									if (led_n >= len_q) begin
										phase_d = wps_pkg::PH_RESET;
									end
								end else begin
									bit_d = bit_q + wps_pkg::BIT_CNT_W'(1);
								end
							end else begin
								tick_d = tick_n;
							end
						end
						wps_pkg::PH_RESET: begin
							level_d        = 1'b0;
							res.line_level = 1'b0;
							res.busy_res   = 1'b1;
							if (tick_n >= rst_len) begin
								tick_d         = '0;
								led_d          = '0;
								bit_d          = '0;
								phase_d        = wps_pkg::PH_IDLE;
								res.frame_done = 1'b1;
							end else begin
								tick_d = tick_n;
							end
						end
						default: begin
							level_d        = 1'b0;
							res.line_level = 1'b0;
							res.busy_res   = 1'b0;
						end
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/wps_outbuf.sv =====
`timescale 1ns / 1ps
// Output register with a skid stage for result words.
// Depends on wps_pkg.
module wps_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  wps_pkg::result_t din,
	output logic             can_accept,
	output logic             valid,
	input  logic             ready,
	output wps_pkg::result_t dout
);

	logic             out_valid_q;
	logic             skid_valid_q;
	wps_pkg::result_t out_q;
	wps_pkg::result_t skid_q;
	logic             slot_free;

	assign slot_free  = !out_valid_q || ready;
	assign can_accept = !skid_valid_q;
	assign valid      = out_valid_q;
	assign dout       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_q <= skid_valid_q ? skid_q : din;
		end else if (acc) begin
			skid_q <= din;
		end
	end

endmodule

// ===== hdl/ws2812_pixel_serializer_top.sv =====
`timescale 1ns / 1ps
// Top level of the LED pixel serializer: request channel, result channel, register port.
// Depends on wps_pkg, wps_if, wps_engine and wps_outbuf.
//
// Pixels (24-bit GRB) live in a single RAM of NUM_LEDS words; a refresh sends the first
// N of them, G, R, B order, MSB first, as pulse-width bit cells, then a low reset period.
// Every request word yields one result word; a tick word gives the line level for that
// tick. The block takes one word per clock cycle while the result buffer can accept it:
// each tick updates the timing counters, and the next pixel is prefetched from the RAM
// read port well before the last bit of the current one. After reset the RAM is zeroed
// by a sweep over all NUM_LEDS words during which no request word is taken; register
// writes are taken at any time. Results pass an output register and a skid stage, so a
// stalled result costs at most one extra word of buffering before ready drops.
module ws2812_pixel_serializer_top #(
	parameter int NUM_LEDS = wps_pkg::NUM_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [wps_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [wps_pkg::CFG_DATA_W-1:0] wr_data,
	wps_req_if.sink                        req,
	wps_res_if.source                      res
);

	wps_pkg::req_item_t item;
	wps_pkg::result_t   eng_res;
	wps_pkg::result_t   out_res;
	logic               clearing;
	logic               can_accept;
	logic               acc;

	assign item.req_type       = req.req_type;
	assign item.index_or_count = req.index_or_count;
	assign item.red            = req.red;
	assign item.green          = req.green;
	assign item.blue           = req.blue;

	assign req.ready = can_accept && !clearing;
	assign acc       = req.valid && req.ready;

	wps_engine #(
		.NUM_LEDS (NUM_LEDS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.acc      (acc),
		.item     (item),
		.res      (eng_res),
		.clearing (clearing)
	);

	wps_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.din        (eng_res),
		.can_accept (can_accept),
		.valid      (res.valid),
		.ready      (res.ready),
		.dout       (out_res)
	);

	assign res.line_level = out_res.line_level;
	assign res.busy_res   = out_res.busy_res;
	assign res.frame_done = out_res.frame_done;

endmodule
